// ----- rtl/core/base32_stream_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// base32 stream encoder assertion macros
// Clocked assertion helpers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef BASE32_STREAM_ENCODER_ASSERT_SVH
`define BASE32_STREAM_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define B32E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication checked on every rising clock edge outside reset
`define B32E_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define B32E_ASSERT(label, prop, msg)
`define B32E_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/b32e_pkg.sv -----
// ----------------------------------------------------------------------------
// b32e_pkg
// Types, constants and helper functions of the base32 stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b32e_pkg;

  localparam int unsigned NumSlots = 8;
  localparam logic [7:0]  PadChar  = 8'h3D;
  localparam logic [2:0]  LastPhase = 3'd4;

  typedef logic [4:0] sym_t;
  typedef logic [7:0] char_t;

  // characters produced by one input beat, slot 0 goes out first
  typedef struct packed {
    logic [NumSlots-1:0][7:0] chars;
    logic [3:0]               count;
    logic                     last;
  } group_t;

  // bits carried into a phase
  function automatic logic [2:0] held_bits(input logic [2:0] phase);
    logic [2:0] res;
    case (phase)
      3'd1:    res = 3'd3;
      3'd2:    res = 3'd1;
      3'd3:    res = 3'd4;
      3'd4:    res = 3'd2;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

  // characters already sent in the group before a phase
  function automatic logic [3:0] chars_before(input logic [2:0] phase);
    logic [3:0] res;
    case (phase)
      3'd1:    res = 4'd1;
      3'd2:    res = 4'd3;
      3'd3:    res = 4'd4;
      3'd4:    res = 4'd6;
      default: res = 4'd0;
    endcase
    return res;
  endfunction

  function automatic logic [3:0] low_mask(input logic [2:0] nbits);
    logic [4:0] full;
    full = (5'd1 << nbits) - 5'd1;
    return full[3:0];
  endfunction

  // a-z then 2-7
  function automatic char_t alpha_char(input sym_t sym);
    char_t res;
    if (sym < 5'd26) begin
      res = 8'h61 + {3'b000, sym};
    end else begin
      res = 8'h32 + {3'b000, sym - 5'd26};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/b32e_if.sv -----
// ----------------------------------------------------------------------------
// b32e_in_if / b32e_out_if
// Valid/ready channels carrying message bytes in and characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b32e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       final_char;

  modport source (output valid, output out_char, output final_char, input ready);
  modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/b32e_symbolizer.sv -----
// ----------------------------------------------------------------------------
// b32e_symbolizer
// Turns one byte plus carried bits into its characters, padding on the final.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_symbolizer (
  input  logic [7:0]       data_byte_i,
  input  logic             final_byte_i,
  input  logic [2:0]       phase_i,
  input  logic [3:0]       leftover_i,
  output b32e_pkg::group_t group_o,
  output logic [2:0]       phase_o,
  output logic [3:0]       leftover_o
);
  import b32e_pkg::*;

  logic [2:0]  phase;
  logic [2:0]  nheld;
  logic [11:0] acc;
  logic [3:0]  nbits;
  logic        two;
  logic [3:0]  nchars;
  logic [2:0]  rem;
  logic [3:0]  acc_low;
  logic [8:0]  tail_w;
  sym_t        sym0;
  sym_t        sym1;
  sym_t        tail;

  always_comb begin
    phase   = (phase_i > LastPhase) ? 3'd0 : phase_i;
    nheld   = held_bits(phase);
    acc     = {leftover_i & low_mask(nheld), data_byte_i};
    nbits   = 4'd8 + {1'b0, nheld};
    two     = (nbits >= 4'd10);
    nchars  = two ? 4'd2 : 4'd1;
    sym0    = 5'(acc >> (nbits - 4'd5));
    sym1    = two ? 5'(acc >> (nbits - 4'd10)) : 5'd0;
    rem     = 3'(nbits - (two ? 4'd10 : 4'd5));
    acc_low = acc[3:0] & low_mask(rem);
    // leftover bits padded on the right with zeros
    tail_w  = {5'd0, acc_low} << (3'd5 - rem);
    tail    = tail_w[4:0];

    for (int i = 0; i < NumSlots; i++) begin
      if (i == 0) begin
        group_o.chars[i] = alpha_char(sym0);
      end else if (i == 1 && two) begin
        group_o.chars[i] = alpha_char(sym1);
      end else if (4'(i) == nchars && rem != 3'd0) begin
        group_o.chars[i] = alpha_char(tail);
      end else begin
        group_o.chars[i] = PadChar;
      end
    end

    group_o.count = final_byte_i ? 4'(NumSlots) - chars_before(phase) : nchars;
    group_o.last  = final_byte_i;

    if (final_byte_i || phase == LastPhase) begin
      phase_o = 3'd0;
    end else begin
      phase_o = phase + 3'd1;
    end
    leftover_o = final_byte_i ? 4'd0 : acc_low;
  end

endmodule

`default_nettype wire

// ----- rtl/core/base32_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base32_stream_encoder
// Streaming base32 encoder, lowercase alphabet, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one message byte per beat with final_byte set on the last
//   byte of the message. out_o carries one ASCII character per beat, most
//   significant bits first, with final_char set on the last character.
//   Each byte is turned into its characters in the accept cycle and parked in
//   a character buffer, which drains through a registered output stage.
//   An accepted byte reaches out_o through the character buffer and then
//   the registered output stage.
//   Throughput: a plain byte yields one or two characters and the final
//   byte of a group with padding up to eight; the output port drains one
//   character per cycle while out_o.ready is high and sets the pace.
//   The next byte is taken in the cycle the buffer hands over its last
//   character, so the buffer never idles while bytes wait.
//   Reset clears group position, carried bits, buffer and output valid.
//   A stalled receiver holds the output beat; the buffer then fills and
//   in_i.ready drops until characters move again. Nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module base32_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  b32e_in_if.sink    in_i,
  b32e_out_if.source out_o
);
  import b32e_pkg::*;

`include "base32_stream_encoder_assert.svh"

  logic [2:0]  phase_q, phase_d, phase_nx;
  logic [3:0]  leftover_q, leftover_d, leftover_nx;
  group_t      group;
  logic [NumSlots-1:0][7:0] buf_chars_q, buf_chars_d;
  logic [3:0]  buf_cnt_q, buf_cnt_d;
  logic        buf_last_q, buf_last_d;
  logic        out_valid_q, out_valid_d;
  char_t       out_char_q, out_char_d;
  logic        out_final_q, out_final_d;
  logic        out_load;
  logic        in_ready;
  logic        in_fire;
  logic        final_fire;

  b32e_symbolizer u_symbolizer (
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .phase_i      (phase_q),
    .leftover_i   (leftover_q),
    .group_o      (group),
    .phase_o      (phase_nx),
    .leftover_o   (leftover_nx)
  );

  assign out_load   = (buf_cnt_q != 4'd0) && (!out_valid_q || out_o.ready);
  assign in_ready   = (buf_cnt_q == 4'd0) || (buf_cnt_q == 4'd1 && out_load);
  assign in_fire    = in_i.valid && in_ready;
  assign final_fire = in_fire && in_i.final_byte;

  always_comb begin
    phase_d     = phase_q;
    leftover_d  = leftover_q;
    buf_chars_d = buf_chars_q;
    buf_cnt_d   = buf_cnt_q;
    buf_last_d  = buf_last_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_final_d = out_final_q;

    if (in_fire) begin
      phase_d     = phase_nx;
      leftover_d  = leftover_nx;
      buf_chars_d = group.chars;
      buf_cnt_d   = group.count;
      buf_last_d  = group.last;
    end else if (out_load) begin
      // shift the next character into slot 0
      buf_chars_d = {8'h00, buf_chars_q[NumSlots-1:1]};
      buf_cnt_d   = buf_cnt_q - 4'd1;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      out_char_d  = buf_chars_q[0];
      out_final_d = buf_last_q && (buf_cnt_q == 4'd1);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 3'd0;
      leftover_q  <= 4'd0;
      buf_cnt_q   <= 4'd0;
      buf_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      leftover_q  <= leftover_d;
      buf_cnt_q   <= buf_cnt_d;
      buf_last_q  <= buf_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_chars_q <= buf_chars_d;
    out_char_q  <= out_char_d;
    out_final_q <= out_final_d;
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.out_char   = out_char_q;
  assign out_o.final_char = out_final_q;

  `B32E_ASSERT(a_phase_range, phase_q <= LastPhase, "group phase out of range")
  `B32E_ASSERT(a_no_carry_at_start, phase_q != 3'd0 || leftover_q == 4'd0, "stray carry")
  `B32E_ASSERT_IMP(a_final_resets, final_fire, {phase_q, leftover_q} == 7'd0, "state kept")
  `B32E_ASSERT_IMP(a_final_flagged, out_load && out_final_d, out_final_q, "final not flagged")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: base32 stream encoder bench
// Sends messages of random length and content, with directed edge cases first.
// A scoreboard encodes every accepted byte itself and compares each output
// beat in order. Random gaps are applied on both channels, with long output
// stalls and a sender pause that lets the encoder drain.
// ----------------------------------------------------------------------------
module tb_top;
  import b32e_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  fin;
  } enc_char_t;

  class b32_scoreboard;
    localparam string SymSet = "abcdefghijklmnopqrstuvwxyz234567";

    enc_char_t   pending_chars[$];
    int unsigned phase;
    logic [3:0]  carry;

    function new();
      phase = 0;
      carry = 4'h0;
    endfunction

    function int unsigned pending();
      return pending_chars.size();
    endfunction

    function void push_char(char_t ch);
      enc_char_t item;
      item.ch  = ch;
      item.fin = 1'b0;
      pending_chars.push_back(item);
    endfunction

    // encode one accepted byte into the characters it releases
    function void encode_byte(logic [7:0] data, logic last);
      int unsigned held, bits, used, nchars, acc;
      held   = (phase * 8) % 5;
      acc    = ((int'(carry) & ((1 << held) - 1)) << 8) | int'(data);
      bits   = held + 8;
      nchars = 0;
      while (bits >= 5) begin
        bits -= 5;
        push_char(char_t'(SymSet[(acc >> bits) & 31]));
        nchars++;
      end
      acc &= (1 << bits) - 1;
      used = (phase * 8) / 5 + nchars;
      if (!last) begin
        phase = (phase + 1) % 5;
        carry = acc[3:0];
        return;
      end
      // zero-pad the trailing bits into one more symbol
      if (bits > 0) begin
        push_char(char_t'(SymSet[(acc << (5 - bits)) & 31]));
        used++;
      end
      while (used < 8) begin
        push_char(PadChar);
        used++;
      end
      pending_chars[pending_chars.size() - 1].fin = 1'b1;
      phase = 0;
      carry = 4'h0;
    endfunction

    function string check_char(char_t ch, logic fin);
      enc_char_t want;
      string     msg;
      if (pending_chars.size() == 0) begin
        return $sformatf("unexpected char %h final %b", ch, fin);
      end
      want = pending_chars.pop_front();
      msg  = "";
      if (ch !== want.ch) begin
        msg = $sformatf("char %h, expected %h ", ch, want.ch);
      end
      if (fin !== want.fin) begin
        msg = {msg, $sformatf("final %b, expected %b", fin, want.fin)};
      end
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   errors;
  int   chars_seen;
  int   sent_bytes;

  b32_scoreboard sb;

  b32e_in_if  in_bus ();
  b32e_out_if out_bus ();

  base32_stream_encoder uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic last, input int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= data;
    in_bus.final_byte <= last;
    do @(posedge clk); while (!in_bus.ready);
    sb.encode_byte(data, last);
    sent_bytes++;
  endtask

  task automatic send_message(input logic [7:0] bytes[$], input bit steady);
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == bytes.size() - 1, steady ? 0 : pick_gap());
    end
  endtask

  // stop offering the last byte again, then wait for every character
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // output monitor
  always @(posedge clk) begin : char_monitor
    string msg;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      chars_seen++;
      msg = sb.check_char(out_bus.out_char, out_bus.final_char);
      if (msg != "") begin
        report_mismatch(msg);
      end
    end
  end

  // receiver: random stalls, steady stretches, and long hold-offs
  initial begin : char_sink
    int unsigned stall_left;
    bit          steady;
    bit          held_once;
    bit          held_twice;
    stall_left    = 0;
    steady        = 1'b0;
    held_once     = 1'b0;
    held_twice    = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 49) == 0) begin
        steady = !steady;
      end
      if (!held_once && chars_seen >= 100) begin
        held_once  = 1'b1;
        stall_left = 120;
      end else if (!held_twice && chars_seen >= 400) begin
        held_twice = 1'b1;
        stall_left = 150;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] msg_bytes[$];
    int unsigned len;
    bit          paused;
    clk               = 1'b0;
    rst_n             = 1'b0;
    errors            = 0;
    chars_seen        = 0;
    sent_bytes        = 0;
    paused            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = 8'h00;
    in_bus.final_byte = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every group length 1..5, padding from six '=' down to none
    send_message('{8'hFF}, 1'b0);
    send_message('{8'h00}, 1'b0);
    send_message('{8'h00, 8'hFF}, 1'b1);
    send_message('{8'hFF, 8'h00, 8'hFF}, 1'b0);
    send_message('{8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b1);
    // final on a full group
    send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
    // group wraps, then a single leftover byte
    send_message('{8'h00, 8'h44, 8'h32, 8'h14, 8'hC7, 8'hA5}, 1'b1);
    wait_drained();

    while (sent_bytes < 330) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      msg_bytes.delete();
      repeat (len) msg_bytes.push_back(pick_byte());
      send_message(msg_bytes, $urandom_range(0, 3) == 0);
      if (!paused && sent_bytes >= 170) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/b32e_pkg.sv
rtl/core/b32e_if.sv
rtl/core/b32e_symbolizer.sv
rtl/core/base32_stream_encoder.sv
bench/tb_top.sv
